>>> hw/rtl/cds_pkg.sv
// Shared codes, constants and functions for the calendar date stepper.
// Holds the month-length function used by the load check and the stepping loop.
// No dependencies.
package cds_pkg;

  // Field widths
  localparam int unsigned DayW   = 5;
  localparam int unsigned MonthW = 4;
  localparam int unsigned YearW  = 14;
  localparam int unsigned CountFieldW = 16;
  // year / 100 fits 8 bits for any 14-bit year, year % 100 fits 7 bits
  localparam int unsigned CentW  = 8;
  localparam int unsigned YremW  = 7;

  // Action codes
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_ADVANCE = 2'd1;
  localparam logic [1:0] ACT_RETREAT = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_DAY  = 2'd1;
  localparam logic [1:0] ST_BAD_YEAR = 2'd2;
  localparam logic [1:0] ST_LIMIT    = 2'd3;

  // Calendar constants
  localparam logic [MonthW-1:0] MONTH_JAN = 4'd1;
  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [MonthW-1:0] MONTH_APR = 4'd4;
  localparam logic [MonthW-1:0] MONTH_JUN = 4'd6;
  localparam logic [MonthW-1:0] MONTH_SEP = 4'd9;
  localparam logic [MonthW-1:0] MONTH_NOV = 4'd11;
  localparam logic [MonthW-1:0] MONTH_DEC = 4'd12;

  localparam logic [YearW-1:0] YEAR_MIN = 14'd1900;
  localparam logic [YearW-1:0] YEAR_MAX = 14'd9999;

  localparam logic [DayW-1:0]  DAY_FIRST = 5'd1;
  localparam logic [DayW-1:0]  DAY_LAST_DEC = 5'd31;
  localparam logic [YremW-1:0] YREM_LAST = 7'd99;

  // Reset date: 1 January 1970
  localparam logic [DayW-1:0]   RST_DAY   = 5'd1;
  localparam logic [MonthW-1:0] RST_MONTH = 4'd1;
  localparam logic [YearW-1:0]  RST_YEAR  = 14'd1970;
  localparam logic [CentW-1:0]  RST_CENT  = 8'd19;
  localparam logic [YremW-1:0]  RST_YREM  = 7'd70;

  // Reciprocal for year / 100: (y * 5243) >> 19 is exact for y < 43699
  localparam int unsigned DivMulW   = 13;
  localparam logic [DivMulW-1:0] DIV100_MUL = 13'd5243;
  localparam int unsigned DivShift  = 19;
  localparam int unsigned DivProdW  = YearW + DivMulW;

  // Days in a month; months outside 1..12 give 31 and are rejected elsewhere
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] month,
                                                input logic              leap);
    logic [DayW-1:0] len;
    len = 5'd31;
    if (month == MONTH_APR || month == MONTH_JUN ||
        month == MONTH_SEP || month == MONTH_NOV) begin
      len = 5'd30;
    end else if (month == MONTH_FEB) begin
      len = leap ? 5'd29 : 5'd28;
    end
    return len;
  endfunction

  // Leap year from the year split as cent * 100 + yrem
  function automatic logic is_leap(input logic [CentW-1:0] cent,
                                   input logic [YremW-1:0] yrem);
    return (yrem[1:0] == 2'b00) && ((yrem != '0) || (cent[1:0] == 2'b00));
  endfunction

endpackage

>>> hw/rtl/calendar_date_stepper.sv
// Gregorian date stepper: holds a date and loads, advances or retreats it.
// Depends on cds_pkg for codes, constants and the month-length function.
//
// Usage: one command transaction in (action, load fields, day_count), one
// result transaction out (date after the command and a status code). Both
// channels use valid/stall; a transaction moves on a clock edge with valid
// high and stall low.
// Sequence: a load passes S_LDIV and S_LCHK to S_DONE, action 3 goes to
// S_DONE directly, and advance/retreat pass through S_STEP, crossing one
// month boundary per pass, before S_DONE writes the result register. The
// month loop runs on one shared subtractor that reduces the remaining count
// each cycle by the days to the next (on retreat, previous) month boundary.
// One command is in flight at a time: in_stall_o stays high from acceptance
// until the result is written to the output register, so the next command
// is taken in the cycle after that. A waiting result does not block the
// next command; only a command that finishes while the previous result is
// still stalled waits for the output register.
// Reset: the date becomes 1 January 1970 and the output register empties.
module calendar_date_stepper
  import cds_pkg::*;
#(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // command channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic [DayW-1:0]      load_day_i,
  input  logic [MonthW-1:0]    load_month_i,
  input  logic [YearW-1:0]     load_year_i,
  input  logic [CountFieldW-1:0] day_count_i,
  // result channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [DayW-1:0]      out_day_o,
  output logic [MonthW-1:0]    out_month_o,
  output logic [YearW-1:0]     out_year_o,
  output logic [1:0]           status_o
);

  localparam int unsigned CntInW = (COUNT_BITS < CountFieldW) ? COUNT_BITS : CountFieldW;
  localparam int unsigned DiffW  = ((COUNT_BITS > DayW) ? COUNT_BITS : DayW) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LDIV,
    S_LCHK,
    S_STEP,
    S_DONE
  } state_e;

  state_e                state_q;
  logic                  dir_back_q;
  logic [COUNT_BITS-1:0] rem_cnt_q;
  logic [1:0]            status_q;

  // current date, year also kept as cent * 100 + yrem for the leap test
  logic [DayW-1:0]   day_q;
  logic [MonthW-1:0] month_q;
  logic [YearW-1:0]  year_q;
  logic [CentW-1:0]  cent_q;
  logic [YremW-1:0]  yrem_q;

  // latched load fields
  logic [DayW-1:0]   ld_day_q;
  logic [MonthW-1:0] ld_month_q;
  logic [YearW-1:0]  ld_year_q;
  logic [CentW-1:0]  ld_cent_q;

  // output register
  logic              out_valid_q;
  logic [DayW-1:0]   out_day_q;
  logic [MonthW-1:0] out_month_q;
  logic [YearW-1:0]  out_year_q;
  logic [1:0]        out_status_q;

  logic                  in_take;
  logic                  out_free;
  logic                  out_load;
  logic [COUNT_BITS-1:0] cnt_init;

  // load path
  logic [DivProdW-1:0] div_prod;
  logic [YearW:0]      cent_x100;
  logic [YearW:0]      ld_rem_full;
  logic [YremW-1:0]    ld_yrem;
  logic                ld_leap;
  logic [DayW-1:0]     ld_mlen;
  logic                ld_day_ok;
  logic                ld_year_ok;

  // stepping path
  logic              cur_leap;
  logic [DayW-1:0]   cur_mlen;
  logic [DayW-1:0]   sub_op;
  logic [DiffW-1:0]  diff;
  logic              borrow;
  logic [DayW-1:0]   rem_small;
  logic [DiffW-1:0]  rem_ext;
  logic              at_top;
  logic              at_bottom;

  logic [MonthW-1:0] fwd_month;
  logic [YearW-1:0]  fwd_year;
  logic [CentW-1:0]  fwd_cent;
  logic [YremW-1:0]  fwd_yrem;
  logic [MonthW-1:0] bwd_month;
  logic [YearW-1:0]  bwd_year;
  logic [CentW-1:0]  bwd_cent;
  logic [YremW-1:0]  bwd_yrem;
  logic [DayW-1:0]   bwd_mlen;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_load   = (state_q == S_DONE) && out_free;
  assign cnt_init   = COUNT_BITS'(day_count_i[CntInW-1:0]);

  // Load: year / 100 by reciprocal, remainder by shift-add in the next cycle
  assign div_prod    = DivProdW'(ld_year_q) * DivProdW'(DIV100_MUL);
  assign cent_x100   = ((YearW+1)'(ld_cent_q) << 6) + ((YearW+1)'(ld_cent_q) << 5)
                     + ((YearW+1)'(ld_cent_q) << 2);
  assign ld_rem_full = (YearW+1)'(ld_year_q) - cent_x100;
  assign ld_yrem     = ld_rem_full[YremW-1:0];
  assign ld_leap     = is_leap(ld_cent_q, ld_yrem);
  assign ld_mlen     = month_len(ld_month_q, ld_leap);
  assign ld_day_ok   = (ld_month_q >= MONTH_JAN) && (ld_month_q <= MONTH_DEC) &&
                       (ld_day_q != '0) && (ld_day_q <= ld_mlen);
  assign ld_year_ok  = (ld_year_q >= YEAR_MIN) && (ld_year_q <= YEAR_MAX);

  // Shared subtractor: count minus days to next boundary (fwd) or day (bwd)
  assign cur_leap  = is_leap(cent_q, yrem_q);
  assign cur_mlen  = month_len(month_q, cur_leap);
  assign sub_op    = dir_back_q ? day_q : (cur_mlen - day_q + DAY_FIRST);
  assign rem_ext   = DiffW'(rem_cnt_q);
  assign diff      = rem_ext - DiffW'(sub_op);
  assign borrow    = diff[DiffW-1];
  assign rem_small = rem_ext[DayW-1:0];
  assign at_top    = (month_q == MONTH_DEC) && (year_q == YEAR_MAX);
  assign at_bottom = (month_q == MONTH_JAN) && (year_q == YEAR_MIN);

  // Next month forward
  always_comb begin
    fwd_month = month_q + MONTH_JAN;
    fwd_year  = year_q;
    fwd_cent  = cent_q;
    fwd_yrem  = yrem_q;
    if (month_q == MONTH_DEC) begin
      fwd_month = MONTH_JAN;
      fwd_year  = year_q + YearW'(1);
      if (yrem_q == YREM_LAST) begin
        fwd_yrem = '0;
        fwd_cent = cent_q + CentW'(1);
      end else begin
        fwd_yrem = yrem_q + YremW'(1);
      end
    end
  end

  // Previous month
  always_comb begin
    bwd_month = month_q - MONTH_JAN;
    bwd_year  = year_q;
    bwd_cent  = cent_q;
    bwd_yrem  = yrem_q;
    if (month_q == MONTH_JAN) begin
      bwd_month = MONTH_DEC;
      bwd_year  = year_q - YearW'(1);
      if (yrem_q == '0) begin
        bwd_yrem = YREM_LAST;
        bwd_cent = cent_q - CentW'(1);
      end else begin
        bwd_yrem = yrem_q - YremW'(1);
      end
    end
    bwd_mlen = month_len(bwd_month, is_leap(bwd_cent, bwd_yrem));
  end

  // Sequencer, date registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      out_valid_q  <= 1'b0;
      day_q        <= RST_DAY;
      month_q      <= RST_MONTH;
      year_q       <= RST_YEAR;
      cent_q       <= RST_CENT;
      yrem_q       <= RST_YREM;
      dir_back_q   <= 1'b0;
      rem_cnt_q    <= '0;
      status_q     <= ST_OK;
      ld_day_q     <= '0;
      ld_month_q   <= '0;
      ld_year_q    <= '0;
      ld_cent_q    <= '0;
      out_day_q    <= '0;
      out_month_q  <= '0;
      out_year_q   <= '0;
      out_status_q <= ST_OK;
    end else begin
      // result register fills from S_DONE, empties on a result transaction
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_take) begin
            ld_day_q   <= load_day_i;
            ld_month_q <= load_month_i;
            ld_year_q  <= load_year_i;
            rem_cnt_q  <= cnt_init;
            status_q   <= ST_OK;
            dir_back_q <= (action_i == ACT_RETREAT);
            if (action_i == ACT_LOAD) begin
              state_q <= S_LDIV;
            end else if (action_i == ACT_ADVANCE || action_i == ACT_RETREAT) begin
              state_q <= S_STEP;
            end else begin
              state_q <= S_DONE;
            end
          end
        end
        S_LDIV: begin
          ld_cent_q <= div_prod[DivShift +: CentW];
          state_q   <= S_LCHK;
        end
        S_LCHK: begin
          if (!ld_day_ok) begin
            status_q <= ST_BAD_DAY;
          end else if (!ld_year_ok) begin
            status_q <= ST_BAD_YEAR;
          end else begin
            day_q   <= ld_day_q;
            month_q <= ld_month_q;
            year_q  <= ld_year_q;
            cent_q  <= ld_cent_q;
            yrem_q  <= ld_yrem;
          end
          state_q <= S_DONE;
        end
        S_STEP: begin
          if (rem_cnt_q == '0) begin
            state_q <= S_DONE;
          end else if (!dir_back_q) begin
            if (borrow) begin
              day_q   <= day_q + rem_small;
              state_q <= S_DONE;
            end else if (at_top) begin
              day_q    <= DAY_LAST_DEC;
              status_q <= ST_LIMIT;
              state_q  <= S_DONE;
            end else begin
              rem_cnt_q <= diff[COUNT_BITS-1:0];
              day_q     <= DAY_FIRST;
              month_q   <= fwd_month;
              year_q    <= fwd_year;
              cent_q    <= fwd_cent;
              yrem_q    <= fwd_yrem;
            end
          end else begin
            if (borrow) begin
              day_q   <= day_q - rem_small;
              state_q <= S_DONE;
            end else if (at_bottom) begin
              day_q    <= DAY_FIRST;
              status_q <= ST_LIMIT;
              state_q  <= S_DONE;
            end else begin
              rem_cnt_q <= diff[COUNT_BITS-1:0];
              day_q     <= bwd_mlen;
              month_q   <= bwd_month;
              year_q    <= bwd_year;
              cent_q    <= bwd_cent;
              yrem_q    <= bwd_yrem;
            end
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_day_q    <= day_q;
            out_month_q  <= month_q;
            out_year_q   <= year_q;
            out_status_q <= status_q;
            state_q      <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_day_o   = out_day_q;
  assign out_month_o = out_month_q;
  assign out_year_o  = out_year_q;
  assign status_o    = out_status_q;

endmodule
